// File: rtl/core/lcdw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdw_pkg
// Constants and types for the decimal field writer: cursor bases, expander
// control nibbles, divide-by-ten reciprocal and the byte position codes.
// ----------------------------------------------------------------------------
package lcdw_pkg;

   localparam int unsigned DIGITS_DEFAULT = 5;

   localparam logic [7:0] ADDR_BYTE_RESET = 8'd78;

   localparam logic [7:0] LINE0_BASE = 8'h80;
   localparam logic [7:0] LINE1_BASE = 8'hC0;

   // expander bits: EN high with backlight, RS set for character data
   localparam logic [7:0] EN_ON_CMD   = 8'h0C;
   localparam logic [7:0] EN_ON_DATA  = 8'h0D;
   localparam logic [7:0] EN_OFF_CMD  = 8'hF8;
   localparam logic [7:0] EN_OFF_DATA = 8'hF9;

   localparam logic [7:0] NIB_HI_MASK = 8'hF0;
   localparam logic [7:0] NIB_LO_MASK = 8'h0F;

   localparam logic [7:0] ASCII_ZERO = 8'd48;

   // n / 10 == (n * 0xCCCD) >> 19 for every 16-bit n
   localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
   localparam int unsigned DIV10_SHIFT = 19;

   typedef enum logic [2:0] {
      POS_ADDR,
      POS_HI_ON,
      POS_HI_OFF,
      POS_LO_ON,
      POS_LO_OFF
   } byte_pos_type;

endpackage

// File: rtl/core/lcd_decimal_field_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_decimal_field_writer
// Writes a request's 16-bit value as DIGITS decimal characters to a
// character LCD in 4-bit mode behind an I2C port expander.
// ----------------------------------------------------------------------------
// Each request yields 10*DIGITS bus bytes (50 at the default), one per cycle
// while the result side does not stall: for every digit a set-cursor transfer
// and a character transfer, each an address byte and four nibble bytes. A
// taken request first sets the busy register, and the first byte then loads
// into the byte-wide result register; the next request is taken in the cycle
// that loads the final byte of the current one, so back-to-back requests run
// without a gap, paced by that single result register. Digits are produced
// LSB first by a reciprocal-multiply divide-by-ten step, one per cycle,
// alongside the cursor transfer of the first digit.
// ----------------------------------------------------------------------------
module lcd_decimal_field_writer
   import lcdw_pkg::*;
#(
   parameter int unsigned DIGITS = DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_display_line,
   input  logic [5:0]  req_start_column,
   input  logic [15:0] req_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_bus_byte,
   output logic        rsp_begins_transfer,
   output logic        rsp_ends_transfer,
   output logic        rsp_last
);

   localparam int unsigned DIG_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int unsigned CONV_W = $clog2(DIGITS + 1);

   logic [7:0]        addr_byte_ff;

   logic              busy_ff, busy_in;
   logic              line_ff, line_in;
   logic [5:0]        col_ff, col_in;
   logic [DIG_W-1:0]  digit_ff, digit_in;
   logic              xfer_ff, xfer_in;
   byte_pos_type      pos_ff, pos_in;

   logic [15:0]       work_ff, work_in;
   logic [CONV_W-1:0] conv_cnt_ff, conv_cnt_in;
   logic [3:0]        digits_ff [DIGITS];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        bus_byte_ff, bus_byte_in;
   logic              begins_ff, begins_in;
   logic              ends_ff, ends_in;
   logic              last_ff, last_in;

   logic              advance, load, last_byte, req_take;
   logic [31:0]       product;
   logic [12:0]       quot;
   logic [15:0]       quot_x10;
   logic [3:0]        rem;
   logic [7:0]        base, cursor, sym, en_on, en_off, hi_on, lo_on;

   // divide-by-ten step on the held remainder
   assign product  = work_ff * {16'd0, DIV10_RECIP};
   assign quot     = product[31:DIV10_SHIFT];
   assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
   assign rem      = 4'(work_ff - quot_x10);

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign load      = busy_ff && advance;
   assign last_byte = (pos_ff == POS_LO_OFF) && xfer_ff &&
                      (digit_ff == DIG_W'(DIGITS - 1));
   assign req_stall = busy_ff && !(load && last_byte);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      base   = line_ff ? LINE1_BASE : LINE0_BASE;
      cursor = base + {2'b00, col_ff} + 8'(digit_ff) - 8'd1;
      sym    = xfer_ff ? (ASCII_ZERO | {4'd0, digits_ff[digit_ff]}) : cursor;
      en_on  = xfer_ff ? EN_ON_DATA : EN_ON_CMD;
      en_off = xfer_ff ? EN_OFF_DATA : EN_OFF_CMD;
      hi_on  = (sym & NIB_HI_MASK) | en_on;
      lo_on  = {sym[3:0], 4'd0} | en_on;
   end

   always_comb begin
      busy_in      = busy_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      digit_in     = digit_ff;
      xfer_in      = xfer_ff;
      pos_in       = pos_ff;
      work_in      = work_ff;
      conv_cnt_in  = conv_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      bus_byte_in  = bus_byte_ff;
      begins_in    = begins_ff;
      ends_in      = ends_ff;
      last_in      = last_ff;

      if (conv_cnt_ff != '0) begin
         work_in     = {3'd0, quot};
         conv_cnt_in = conv_cnt_ff - CONV_W'(1);
      end

      if (advance) begin
         rsp_valid_in = busy_ff;
      end

      if (load) begin
         begins_in = 1'b0;
         ends_in   = 1'b0;
         last_in   = 1'b0;
         case (pos_ff)
            POS_ADDR: begin
               bus_byte_in = addr_byte_ff;
               begins_in   = 1'b1;
               pos_in      = POS_HI_ON;
            end
            POS_HI_ON: begin
               bus_byte_in = hi_on;
               pos_in      = POS_HI_OFF;
            end
            POS_HI_OFF: begin
               bus_byte_in = hi_on & en_off;
               pos_in      = POS_LO_ON;
            end
            POS_LO_ON: begin
               bus_byte_in = lo_on;
               pos_in      = POS_LO_OFF;
            end
            POS_LO_OFF: begin
               bus_byte_in = lo_on & en_off;
               ends_in     = 1'b1;
               last_in     = last_byte;
               pos_in      = POS_ADDR;
               xfer_in     = !xfer_ff;
               if (xfer_ff) begin
                  digit_in = digit_ff + DIG_W'(1);
               end
               if (last_byte) begin
                  busy_in = 1'b0;
               end
            end
            default: begin
               pos_in = POS_ADDR;
            end
         endcase
      end

      // start a new request; if one was running, its last byte loads this cycle
      if (req_take) begin
         busy_in     = 1'b1;
         line_in     = req_display_line;
         col_in      = req_start_column;
         digit_in    = '0;
         xfer_in     = 1'b0;
         pos_in      = POS_ADDR;
         work_in     = req_value;
         conv_cnt_in = CONV_W'(DIGITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_byte_ff <= ADDR_BYTE_RESET;
         busy_ff      <= 1'b0;
         digit_ff     <= '0;
         xfer_ff      <= 1'b0;
         pos_ff       <= POS_ADDR;
         conv_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            addr_byte_ff <= csr_write_data;
         end
         busy_ff      <= busy_in;
         digit_ff     <= digit_in;
         xfer_ff      <= xfer_in;
         pos_ff       <= pos_in;
         conv_cnt_ff  <= conv_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff     <= line_in;
      col_ff      <= col_in;
      work_ff     <= work_in;
      bus_byte_ff <= bus_byte_in;
      begins_ff   <= begins_in;
      ends_ff     <= ends_in;
      last_ff     <= last_in;
      // shift digits in LSB first so the leftmost lands at index 0
      if (conv_cnt_ff != '0) begin
         digits_ff[0] <= rem;
         for (int i = 1; i < DIGITS; i++) begin
            digits_ff[i] <= digits_ff[i-1];
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_bus_byte        = bus_byte_ff;
   assign rsp_begins_transfer = begins_ff;
   assign rsp_ends_transfer   = ends_ff;
   assign rsp_last            = last_ff;

   // digits must be complete before any character transfer is formed
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && xfer_ff) |-> (conv_cnt_ff == '0))
      else $error("character transfer before digit conversion finished");

   // a taken request restarts the sequence at the first cursor address byte
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=>
         (busy_ff && !xfer_ff && (pos_ff == POS_ADDR) && (digit_ff == '0)))
      else $error("request did not restart the byte sequence");

   // the final byte of a run always closes a transfer
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_ends_transfer && !rsp_begins_transfer))
      else $error("last byte does not end a transfer");

endmodule
